>>> hdl/bba_pkg.sv
// Shared types, sizes and a helper function for the bitmap block allocator.
package bba_pkg;

   localparam int NUM_BLOCKS      = 512;
   localparam int BLOCK_BYTES     = 64;
   localparam int RESERVED_BLOCKS = 2;

   localparam int MAP_WORDS  = (NUM_BLOCKS + 7) / 8;
   localparam int WORD_AW    = $clog2(MAP_WORDS);
   localparam int BLOCK_W    = 9;
   localparam int COUNT_W    = 10;
   localparam int BYTES_W    = 16;
   localparam int BYTE_SHIFT = $clog2(BLOCK_BYTES);
   localparam int AVAIL_W    = COUNT_W + BYTE_SHIFT;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_CHECK    = 2'd2,
      OP_REFORMAT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Map word as it stands after reset or reformat.
   function automatic logic [7:0] reset_word(input logic [WORD_AW-1:0] addr);
      logic [7:0] w;
      int         blk;
      w = '0;
      for (int b = 0; b < 8; b++) begin
         blk  = int'(addr) * 8 + b;
         w[b] = (blk >= RESERVED_BLOCKS) && (blk < NUM_BLOCKS);
      end
      return w;
   endfunction

endpackage

>>> hdl/bitmap_block_allocator_top.sv
// Bitmap free-block allocator: one-word-per-cycle scan of a synchronous map memory.
//
//   channel | direction | words carried
//   req_    | in        | operation, block_index, byte_count
//   rsp_    | out       | granted_block, success, free_blocks
//
// One item at a time. Allocate reads the map words in order from word 0 up to the
// word holding the lowest free block, and its result follows that word: the map
// memory port reads one word per cycle. An allocate on an empty map, check and
// reformat go straight to the result; free first reads and updates its map word.
// After reset the map reads as its reset pattern through per-word valid bits; no
// clearing pass is needed, and reformat clears all those bits together.
// A stalled result waits in the output register; the block accepts the next word
// while it waits and holds its own result until the output register is free.
module bitmap_block_allocator_top
   import bba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [BLOCK_W-1:0]  req_block_index,
   input  logic [BYTES_W-1:0]  req_byte_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BLOCK_W-1:0]  rsp_granted_block,
   output logic                rsp_success,
   output logic [COUNT_W-1:0]  rsp_free_blocks
);

   // map memory and per-word valid bits
   logic [7:0]           map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] map_vld_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_vld_ff;
   logic [WORD_AW-1:0]   rd_addr_ff;

   // control and staging registers
   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [2:0]           bit_ff, bit_in;
   logic [WORD_AW-1:0]   scan_addr_ff, scan_addr_in;
   logic [COUNT_W-1:0]   free_total_ff, free_total_in;
   logic [BLOCK_W-1:0]   res_granted_ff, res_granted_in;
   logic                 res_ok_ff, res_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // memory access controls
   logic                 rd_en;
   logic [WORD_AW-1:0]   rd_addr;
   logic                 wr_en;
   logic [WORD_AW-1:0]   wr_addr;
   logic [7:0]           wr_data;
   logic                 clear_vld;

   logic [7:0]           cur_word;
   logic [2:0]           low_bit;
   logic                 req_take;
   logic [AVAIL_W:0]     avail_bytes;
   logic                 block_in_range;

   assign req_take = req_valid && req_ready;
   assign cur_word = rd_vld_ff ? rd_data_ff : reset_word(rd_addr_ff);
   assign avail_bytes = {1'b0, free_total_ff, {BYTE_SHIFT{1'b0}}};
   assign block_in_range = ({1'b0, req_block_index} < (BLOCK_W+1)'(NUM_BLOCKS));

   // find lowest set bit of the word under scan
   always_comb begin
      low_bit = '0;
      for (int b = 7; b >= 0; b--) begin
         if (cur_word[b]) begin
            low_bit = 3'(b);
         end
      end
   end

   // memory: registered read, one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   // valid bits: reset and reformat return every word to its reset pattern
   always_ff @(posedge clock) begin
      if (reset || clear_vld) begin
         map_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            map_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= map_vld_ff[rd_addr];
         end
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_total_ff <= COUNT_W'(NUM_BLOCKS - RESERVED_BLOCKS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      bit_ff         <= bit_in;
      scan_addr_ff   <= scan_addr_in;
      res_granted_ff <= res_granted_in;
      res_ok_ff      <= res_ok_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // next state, memory commands and results
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      bit_in         = bit_ff;
      scan_addr_in   = scan_addr_ff;
      free_total_in  = free_total_ff;
      res_granted_in = res_granted_ff;
      res_ok_in      = res_ok_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_count_in   = rsp_count_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_addr_ff;
      wr_en          = 1'b0;
      wr_addr        = rd_addr_ff;
      wr_data        = cur_word;
      clear_vld      = 1'b0;
      req_ready      = (state_ff == ST_IDLE);

      // drop the output word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in          = op_type'(req_operation);
               bit_in         = req_block_index[2:0];
               res_granted_in = '0;
               res_ok_in      = 1'b1;
               case (op_type'(req_operation))
                  OP_ALLOC: begin
                     if (free_total_ff == '0) begin
                        res_ok_in = 1'b0;
                        state_in  = ST_DONE;
                     end else begin
                        scan_addr_in = '0;
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (block_in_range) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_block_index[BLOCK_W-1:3];
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_CHECK: begin
                     res_ok_in = (avail_bytes >= {1'b0, req_byte_count});
                     state_in  = ST_DONE;
                  end
                  OP_REFORMAT: begin
                     clear_vld     = 1'b1;
                     free_total_in = COUNT_W'(NUM_BLOCKS - RESERVED_BLOCKS);
                     state_in      = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (op_ff == OP_ALLOC) begin
               if (cur_word != '0) begin
                  // claim the lowest free block of this word
                  wr_en          = 1'b1;
                  wr_data        = cur_word & ~(8'd1 << low_bit);
                  free_total_in  = free_total_ff - 1'b1;
                  res_granted_in = {rd_addr_ff, low_bit};
                  res_ok_in      = 1'b1;
                  state_in       = ST_DONE;
               end else if (scan_addr_ff == WORD_AW'(MAP_WORDS - 1)) begin
                  res_ok_in = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  // advance to the next map word
                  scan_addr_in = scan_addr_ff + 1'b1;
                  rd_en        = 1'b1;
                  rd_addr      = scan_addr_ff + 1'b1;
               end
            end else begin
               // free: set the bit if it was clear
               if (!cur_word[bit_ff]) begin
                  wr_en         = 1'b1;
                  wr_data       = cur_word | (8'd1 << bit_ff);
                  free_total_in = free_total_ff + 1'b1;
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_ok_in      = res_ok_ff;
               rsp_count_in   = free_total_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_success       = rsp_ok_ff;
   assign rsp_free_blocks   = rsp_count_ff;

   // count never exceeds the number of blocks
   assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= COUNT_W'(NUM_BLOCKS))
      else $error("free count above block total");

   // a failed result grants block zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_granted_ff == '0))
      else $error("failed result carries a block number");

   // an accepted word always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("accepted word not processed");

   // a scan for allocation only runs while blocks are free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && op_ff == OP_ALLOC) |-> (free_total_ff != '0))
      else $error("allocation scan with empty map");

endmodule
